### sv/efe_pkg.sv
// Shared types and constants of the eased fade envelope.
// No dependencies; every other file refers to it by scoped names.
package efe_pkg;

    // Width of the window length registers.
    localparam int TICK_W = 31;
    // Width of the ramp fraction t (Q0.16).
    localparam int T_BITS = 16;

    // Configuration register indexes.
    localparam logic [2:0] REG_SECTION_START = 3'd0;
    localparam logic [2:0] REG_SECTION_END   = 3'd1;
    localparam logic [2:0] REG_ENTER_TICKS   = 3'd2;
    localparam logic [2:0] REG_EXIT_TICKS    = 3'd3;
    localparam logic [2:0] REG_EASE_MODE     = 3'd4;

    // Ease codes; the codes above smoothstep act as linear.
    localparam logic [2:0] EASE_LINEAR = 3'd0;
    localparam logic [2:0] EASE_IN     = 3'd1;
    localparam logic [2:0] EASE_OUT    = 3'd2;
    localparam logic [2:0] EASE_IN_OUT = 3'd3;
    localparam logic [2:0] EASE_SMOOTH = 3'd4;

    typedef enum logic [1:0] {
        ZONE_OUTSIDE = 2'd0,
        ZONE_ENTER   = 2'd1,
        ZONE_HOLD    = 2'd2,
        ZONE_EXIT    = 2'd3
    } zone_t;

    // Control that travels alongside the data of each pipeline stage.
    typedef struct packed {
        logic  valid;
        zone_t zone;
    } tag_t;

endpackage

### sv/efe_cfg.sv
// Configuration registers and the window scaler of the eased fade envelope.
// Uses efe_pkg. Scales the windows with a serial multiply and a serial divide.
module efe_cfg #(
    parameter int FRAME_BITS = 32,
    parameter int CFG_W      = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    output logic [FRAME_BITS-1:0]       sec_start,
    output logic [FRAME_BITS-1:0]       sec_end,
    output logic [2:0]                  ease_mode,
    output logic [efe_pkg::TICK_W-1:0]  en_eff,
    output logic [efe_pkg::TICK_W-1:0]  ex_eff,
    output logic                        busy
);
    localparam int TW   = efe_pkg::TICK_W;
    localparam int SW   = FRAME_BITS + 1;
    localparam int PW   = TW + SW;
    localparam int CNTW = $clog2(PW);
    localparam int SIW  = $clog2(SW);
    localparam int CW   = (SW > TW + 1) ? SW : TW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } state_t;

    state_t                state_reg;
    logic [FRAME_BITS-1:0] start_reg;
    logic [FRAME_BITS-1:0] end_reg;
    logic [TW-1:0]         en_reg;
    logic [TW-1:0]         ex_reg;
    logic [2:0]            mode_reg;
    logic [TW-1:0]         en_eff_reg;
    logic [TW-1:0]         ex_eff_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic [PW-1:0]         acc_reg;
    logic [TW:0]           rem_reg;
    logic [TW-1:0]         quo_reg;

    logic [SW-1:0]   size;
    logic [TW:0]     sum;
    logic            scale;
    logic [PW-1:0]   acc_next;
    logic [TW+1:0]   rem_sh;
    logic            q_bit;
    logic [TW:0]     rem_next;
    logic [TW-1:0]   quo_next;
    logic [SW-1:0]   ex_scaled;

    always_comb
    begin
        size      = {end_reg[FRAME_BITS-1], end_reg} - {start_reg[FRAME_BITS-1], start_reg};
        sum       = {1'b0, en_reg} + {1'b0, ex_reg};
        scale     = CW'(sum) > CW'(size);
        acc_next  = {acc_reg[PW-2:0], 1'b0}
                    + (size[cnt_reg[SIW-1:0]] ? PW'(en_reg) : '0);
        rem_sh    = {rem_reg, acc_reg[PW-1]};
        q_bit     = rem_sh >= {1'b0, sum};
        rem_next  = q_bit ? (TW+1)'(rem_sh - {1'b0, sum}) : rem_sh[TW:0];
        quo_next  = {quo_reg[TW-2:0], q_bit};
        ex_scaled = size - SW'(quo_next);
    end

    // The remainder always stays below the window sum, so TW+1 bits hold it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            start_reg  <= '0;
            end_reg    <= '0;
            en_reg     <= '0;
            ex_reg     <= '0;
            mode_reg   <= '0;
            en_eff_reg <= '0;
            ex_eff_reg <= '0;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            rem_reg    <= '0;
            quo_reg    <= '0;
        end
        else
        begin
            priority if (cfg_we)
            begin
                unique case (cfg_index)
                    efe_pkg::REG_SECTION_START: start_reg <= cfg_data[FRAME_BITS-1:0];
                    efe_pkg::REG_SECTION_END:   end_reg   <= cfg_data[FRAME_BITS-1:0];
                    efe_pkg::REG_ENTER_TICKS:   en_reg    <= cfg_data[TW-1:0];
                    efe_pkg::REG_EXIT_TICKS:    ex_reg    <= cfg_data[TW-1:0];
                    efe_pkg::REG_EASE_MODE:     mode_reg  <= cfg_data[2:0];
                    default: ;
                endcase
                state_reg <= S_MUL;
                cnt_reg   <= CNTW'(SW - 1);
                acc_reg   <= '0;
            end
            else if (state_reg == S_MUL)
            begin
                acc_reg <= acc_next;
                if (cnt_reg == '0)
                begin
                    state_reg <= S_DIV;
                    cnt_reg   <= CNTW'(PW - 1);
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            else if (state_reg == S_DIV)
            begin
                acc_reg <= {acc_reg[PW-2:0], 1'b0};
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (cnt_reg == '0)
                begin
                    state_reg  <= S_IDLE;
                    en_eff_reg <= scale ? quo_next : en_reg;
                    ex_eff_reg <= scale ? TW'(ex_scaled) : ex_reg;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign sec_start = start_reg;
    assign sec_end   = end_reg;
    assign ease_mode = mode_reg;
    assign en_eff    = en_eff_reg;
    assign ex_eff    = ex_eff_reg;
    assign busy      = (state_reg != S_IDLE);

endmodule

### sv/efe_front.sv
// Front stages: section test, zone choice and the divider operands.
// Uses efe_pkg. Two register stages, advancing together with the pipeline.
module efe_front #(
    parameter int FRAME_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_v,
    input  logic [FRAME_BITS-1:0]       frame,
    input  logic [FRAME_BITS-1:0]       sec_start,
    input  logic [FRAME_BITS-1:0]       sec_end,
    input  logic [efe_pkg::TICK_W-1:0]  en_eff,
    input  logic [efe_pkg::TICK_W-1:0]  ex_eff,
    output efe_pkg::tag_t               tag_out,
    output logic [efe_pkg::TICK_W-1:0]  num_out,
    output logic [efe_pkg::TICK_W-1:0]  den_out
);
    localparam int TW = efe_pkg::TICK_W;
    localparam int XS = FRAME_BITS + 1;
    localparam int CW = (XS > TW) ? XS : TW;

    logic          v1_reg;
    logic          in_sec_reg;
    logic [XS-1:0] off_reg;
    logic [XS-1:0] to_end_reg;

    logic           tag_v_reg;
    efe_pkg::zone_t tag_z_reg;
    logic [TW-1:0]  num_reg;
    logic [TW-1:0]  den_reg;

    logic          in_sec;
    logic [XS-1:0] off;
    logic [XS-1:0] to_end;
    logic          entering;
    logic          exiting;
    efe_pkg::tag_t tag_next;
    logic [TW-1:0] num_next;
    logic [TW-1:0] den_next;

    always_comb
    begin
        in_sec = ($signed(frame) >= $signed(sec_start)) && ($signed(frame) < $signed(sec_end));
        off    = {frame[FRAME_BITS-1], frame} - {sec_start[FRAME_BITS-1], sec_start};
        to_end = {sec_end[FRAME_BITS-1], sec_end} - {frame[FRAME_BITS-1], frame};
    end

    // A zero window never matches, and the enter window wins where both do.
    always_comb
    begin
        entering       = (en_eff != '0) && (CW'(off_reg) < CW'(en_eff));
        exiting        = (ex_eff != '0) && (CW'(to_end_reg) <= CW'(ex_eff));
        tag_next.valid = v1_reg;
        num_next       = '0;
        den_next       = TW'(1);
        priority if (!in_sec_reg)
        begin
            tag_next.zone = efe_pkg::ZONE_OUTSIDE;
        end
        else if (entering)
        begin
            tag_next.zone = efe_pkg::ZONE_ENTER;
            num_next      = TW'(off_reg);
            den_next      = en_eff;
        end
        else if (exiting)
        begin
            tag_next.zone = efe_pkg::ZONE_EXIT;
            num_next      = ex_eff - TW'(to_end_reg);
            den_next      = ex_eff;
        end
        else
        begin
            tag_next.zone = efe_pkg::ZONE_HOLD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            tag_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= in_v;
            tag_v_reg <= tag_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_sec_reg <= in_sec;
            off_reg    <= off;
            to_end_reg <= to_end;
            tag_z_reg  <= tag_next.zone;
            num_reg    <= num_next;
            den_reg    <= den_next;
        end
    end

    assign tag_out = '{valid: tag_v_reg, zone: tag_z_reg};
    assign num_out = num_reg;
    assign den_out = den_reg;

endmodule

### sv/efe_div_cell.sv
// One cell of the divider chain: a single restoring step that yields one bit of t.
// Uses efe_pkg for the stage tag.
module efe_div_cell #(
    parameter int DW = 31,
    parameter int QW = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  efe_pkg::tag_t  tag_in,
    input  logic [DW-1:0]  rem_in,
    input  logic [DW-1:0]  den_in,
    input  logic [QW-1:0]  q_in,
    output efe_pkg::tag_t  tag_out,
    output logic [DW-1:0]  rem_out,
    output logic [DW-1:0]  den_out,
    output logic [QW-1:0]  q_out
);
    logic           tag_v_reg;
    efe_pkg::zone_t tag_z_reg;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  den_reg;
    logic [QW-1:0]  q_reg;

    logic [DW:0]   rem_sh;
    logic          q_bit;
    logic [DW-1:0] rem_next;

    // The remainder stays below the divisor, so the shifted value is under twice it.
    always_comb
    begin
        rem_sh   = {rem_in, 1'b0};
        q_bit    = rem_sh >= {1'b0, den_in};
        rem_next = q_bit ? DW'(rem_sh - {1'b0, den_in}) : rem_sh[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            tag_v_reg <= tag_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_z_reg <= tag_in.zone;
            rem_reg   <= rem_next;
            den_reg   <= den_in;
            q_reg     <= {q_in[QW-2:0], q_bit};
        end
    end

    assign tag_out = '{valid: tag_v_reg, zone: tag_z_reg};
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign q_out   = q_reg;

endmodule

### sv/efe_ease.sv
// Ease curves, rounding to the weight format and the output register.
// Uses efe_pkg. Three stages, one multiplier level in each of the first two.
module efe_ease #(
    parameter int WF = 15
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  efe_pkg::tag_t               tag_in,
    input  logic [efe_pkg::T_BITS-1:0]  t_in,
    input  logic [2:0]                  ease_mode,
    output logic                        out_v,
    output logic [WF:0]                 weight,
    output logic [1:0]                  zone
);
    localparam int TB = efe_pkg::T_BITS;
    localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
    localparam logic [17:0] THREE_Q16 = 18'd196608;
    localparam logic [WF:0] ONE_W    = (WF+1)'(1) << WF;

    logic           v1_reg;
    efe_pkg::zone_t z1_reg;
    logic [TB-1:0]  t1_reg;
    logic [31:0]    tt1_reg;
    logic [33:0]    uu1_reg;

    logic           v2_reg;
    efe_pkg::zone_t z2_reg;
    logic [TB-1:0]  t2_reg;
    logic [31:0]    tt2_reg;
    logic [33:0]    uu2_reg;
    logic [32:0]    sm2_reg;

    logic          v3_reg;
    logic [WF:0]   w3_reg;
    logic [1:0]    z3_reg;

    logic [16:0]      u;
    logic [17:0]      k;
    logic [49:0]      sm_full;
    logic [32:0]      e;
    logic [32+WF:0]   rnd;
    logic [WF:0]      w_ease;
    logic [WF:0]      w_next;

    always_comb
    begin
        u       = 17'h10000 - {1'b0, t_in};
        k       = THREE_Q16 - {1'b0, t1_reg, 1'b0};
        sm_full = tt1_reg * k;
    end

    always_comb
    begin
        unique case (ease_mode)
            efe_pkg::EASE_IN:     e = {1'b0, tt2_reg};
            efe_pkg::EASE_OUT:    e = ONE_Q32 - uu2_reg[32:0];
            efe_pkg::EASE_IN_OUT: e = t2_reg[TB-1] ? ONE_Q32 - {uu2_reg[31:0], 1'b0}
                                                   : {tt2_reg, 1'b0};
            efe_pkg::EASE_SMOOTH: e = sm2_reg;
            default:              e = {1'b0, t2_reg, 16'h0000};
        endcase
        rnd    = {e, {WF{1'b0}}} + (33+WF)'(ONE_Q32 >> 1);
        w_ease = rnd[32+WF:32];
        unique case (z2_reg)
            efe_pkg::ZONE_ENTER: w_next = w_ease;
            efe_pkg::ZONE_EXIT:  w_next = ONE_W - w_ease;
            efe_pkg::ZONE_HOLD:  w_next = ONE_W;
            default:             w_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= tag_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z1_reg  <= tag_in.zone;
            t1_reg  <= t_in;
            tt1_reg <= t_in * t_in;
            uu1_reg <= 34'(u * u);
            z2_reg  <= z1_reg;
            t2_reg  <= t1_reg;
            tt2_reg <= tt1_reg;
            uu2_reg <= uu1_reg;
            sm2_reg <= sm_full[48:16];
            w3_reg  <= w_next;
            z3_reg  <= z2_reg;
        end
    end

    assign out_v  = v3_reg;
    assign weight = w3_reg;
    assign zone   = z3_reg;

endmodule

### sv/eased_fade_envelope.sv
// Eased fade envelope: maps each frame number to a fade weight and its zone.
// Uses efe_pkg, efe_cfg, efe_front, efe_div_cell and efe_ease.
//
// One frame is taken every clock cycle while in_stall is low, and its weight passes
// through the input register, two front stages, a chain of 16 divider cells that
// produce one bit of the ramp fraction each, and three ease stages ending in the
// output register. The whole pipeline holds while a finished beat waits on out_stall.
// Every configuration write restarts the window scaler, a bit-serial multiply
// and divide; in_stall is high while it runs, so write the registers and then wait
// before sending frames.
module eased_fade_envelope #(
    parameter int WEIGHT_FRAC_BITS = 15,
    parameter int FRAME_BITS       = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [((FRAME_BITS > efe_pkg::TICK_W) ? FRAME_BITS : efe_pkg::TICK_W)-1:0]
                                        cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [FRAME_BITS-1:0]       current_frame,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [WEIGHT_FRAC_BITS:0]   weight,
    output logic [1:0]                  zone
);
    localparam int CFG_W = (FRAME_BITS > efe_pkg::TICK_W) ? FRAME_BITS : efe_pkg::TICK_W;
    localparam int TW    = efe_pkg::TICK_W;
    localparam int TB    = efe_pkg::T_BITS;

    logic                  adv;
    logic                  busy;
    logic                  in_v_reg;
    logic [FRAME_BITS-1:0] frame_reg;

    logic [FRAME_BITS-1:0] sec_start;
    logic [FRAME_BITS-1:0] sec_end;
    logic [2:0]            ease_mode;
    logic [TW-1:0]         en_eff;
    logic [TW-1:0]         ex_eff;

    efe_pkg::tag_t         tag_c [0:TB];
    logic [TW-1:0]         rem_c [0:TB];
    logic [TW-1:0]         den_c [0:TB];
    logic [TB-1:0]         q_c   [0:TB];

    assign adv      = !out_valid || !out_stall;
    assign in_stall = busy || !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_v_reg <= in_valid && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            frame_reg <= current_frame;
        end
    end

    efe_cfg #(
        .FRAME_BITS (FRAME_BITS),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sec_start (sec_start),
        .sec_end   (sec_end),
        .ease_mode (ease_mode),
        .en_eff    (en_eff),
        .ex_eff    (ex_eff),
        .busy      (busy)
    );

    efe_front #(
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_v      (in_v_reg),
        .frame     (frame_reg),
        .sec_start (sec_start),
        .sec_end   (sec_end),
        .en_eff    (en_eff),
        .ex_eff    (ex_eff),
        .tag_out   (tag_c[0]),
        .num_out   (rem_c[0]),
        .den_out   (den_c[0])
    );

    assign q_c[0] = '0;

    for (genvar i = 0; i < TB; i++)
    begin : g_div
        efe_div_cell #(
            .DW (TW),
            .QW (TB)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tag_in  (tag_c[i]),
            .rem_in  (rem_c[i]),
            .den_in  (den_c[i]),
            .q_in    (q_c[i]),
            .tag_out (tag_c[i+1]),
            .rem_out (rem_c[i+1]),
            .den_out (den_c[i+1]),
            .q_out   (q_c[i+1])
        );
    end

    efe_ease #(
        .WF (WEIGHT_FRAC_BITS)
    ) u_ease (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .tag_in    (tag_c[TB]),
        .t_in      (q_c[TB]),
        .ease_mode (ease_mode),
        .out_v     (out_valid),
        .weight    (weight),
        .zone      (zone)
    );

endmodule
